/* sv/updec_pkg.sv */
// updec_pkg: types, character constants and the hex-digit helper for the
// URL percent-decoder. No dependencies.

package updec_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HEX1 = 2'd2
    } t_phase;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_res;

    // results produced by one item, slot 0 first
    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
    } t_push;

    // returns {is_hex, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

/* sv/updec_in_if.sv */
// updec_in_if: input channel of the percent-decoder, one encoded byte per item.
// Stands alone; no package needed.

interface updec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* sv/updec_out_if.sv */
// updec_out_if: output channel of the percent-decoder, one decoded byte per item.
// Stands alone; no package needed.

interface updec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* sv/updec_dec.sv */
// updec_dec: input register, escape phase state and the decode logic that
// turns one byte into zero, one or two results. Uses updec_pkg, updec_in_if.

module updec_dec (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    updec_in_if.sink             i_in,
    input  logic                 i_room,
    output updec_pkg::t_push     o_push
);
    import updec_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    t_phase     r_phase, n_phase;
    logic [3:0] r_held, n_held;

    logic       adv;
    logic [4:0] hv;
    logic       esc_v, pl_v, fl_v, do_plain;
    logic [7:0] esc_d, pl_d, fl_d;
    logic [1:0] cnt;
    t_res       s0, s1;

    assign adv        = r_valid && i_room;
    assign i_in.ready = !r_valid || i_room;
    assign hv         = hex_value(r_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= PH_IDLE;
            r_held  <= 4'd0;
        end else begin
            if (i_in.ready) begin
                r_valid <= i_in.valid;
            end
            if (adv) begin
                r_phase <= n_phase;
                r_held  <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.in_last;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        esc_v    = 1'b0;
        esc_d    = 8'd0;
        do_plain = 1'b0;
        case (r_phase)
            PH_PCT: begin
                if (hv[4]) begin
                    n_held  = hv[3:0];
                    n_phase = PH_HEX1;
                end else begin
                    esc_v    = 1'b1;
                    esc_d    = CH_PCT;
                    n_phase  = PH_IDLE;
                    do_plain = 1'b1;
                end
            end
            PH_HEX1: begin
                esc_v   = 1'b1;
                n_phase = PH_IDLE;
                if (hv[4]) begin
                    esc_d = {r_held, hv[3:0]};
                end else begin
                    // broken escape: lone digit goes out as its value
                    esc_d    = {4'd0, r_held};
                    do_plain = 1'b1;
                end
            end
            default: begin
                n_phase  = PH_IDLE;
                do_plain = 1'b1;
            end
        endcase

        pl_v = 1'b0;
        pl_d = r_byte;
        if (do_plain) begin
            if (r_byte == CH_PLUS) begin
                pl_v = 1'b1;
                pl_d = CH_SPACE;
            end else if (r_byte == CH_PCT) begin
                n_phase = PH_PCT;
            end else begin
                pl_v = 1'b1;
            end
        end

        // end of string flushes whatever escape is pending
        fl_v = 1'b0;
        fl_d = CH_PCT;
        if (r_last) begin
            if (n_phase == PH_PCT) begin
                fl_v = 1'b1;
            end else if (n_phase == PH_HEX1) begin
                fl_v = 1'b1;
                fl_d = {4'd0, n_held};
            end
            n_phase = PH_IDLE;
            n_held  = 4'd0;
        end

        cnt = {1'b0, esc_v} + {1'b0, pl_v} + {1'b0, fl_v};
        s0  = '{data: fl_d, last: 1'b0};
        s1  = '{data: fl_d, last: 1'b0};
        if (esc_v) begin
            s0.data = esc_d;
            if (pl_v) begin
                s1.data = pl_d;
            end
        end else if (pl_v) begin
            s0.data = pl_d;
        end
        s0.last = r_last && (cnt == 2'd1);
        s1.last = r_last && (cnt == 2'd2);

        o_push.count = adv ? cnt : 2'd0;
        o_push.res0  = s0;
        o_push.res1  = s1;
    end

endmodule

/* sv/updec_queue.sv */
// updec_queue: four-entry result queue, takes up to two results a cycle and
// presents one a cycle while the receiver is ready. Uses updec_pkg, updec_out_if.

module updec_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  updec_pkg::t_push        i_push,
    output logic                    o_room,
    output logic [updec_pkg::Q_CW-1:0] o_level,
    updec_out_if.source             o_out
);
    import updec_pkg::*;

    t_res              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_CW-1:0]   r_cnt, n_cnt;
    logic              pop;
    logic [Q_AW-1:0]   wp1;

    assign pop          = o_out.valid && o_out.ready;
    assign wp1          = r_wp + Q_AW'(1);
    assign o_room       = r_cnt <= Q_CW'(Q_DEPTH - 2);
    assign o_level      = r_cnt;
    assign o_out.valid  = r_cnt != '0;
    assign o_out.out_byte = r_mem[r_rp].data;
    assign o_out.out_last = r_mem[r_rp].last;
    assign n_cnt        = r_cnt + Q_CW'(i_push.count) - Q_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_AW'(i_push.count);
            r_cnt <= n_cnt;
            if (pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wp] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wp1] <= i_push.res1;
        end
    end

endmodule

/* sv/url_percent_decoder.sv */
// url_percent_decoder: top level of the streaming URL percent-decoder.
// Uses updec_pkg, updec_in_if, updec_out_if, updec_dec, updec_queue.
//
//   port    dir  items           payload
//   i_in    in   encoded bytes   in_byte[7:0], in_last
//   o_out   out  decoded bytes   out_byte[7:0], out_last
//
// One input item per cycle unless stalled; its results pass through the input
// register into the queue and leave at one per cycle while the receiver is
// ready, so a byte that yields two results leaves as two output items. An item
// waits in the input register while the queue holds more than two results, and
// the input stalls only while that register is occupied. Synchronous active-low
// reset empties the queue and returns the escape phase to idle.

module url_percent_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    updec_in_if.sink    i_in,
    updec_out_if.source o_out
);
    import updec_pkg::*;

    t_push           push;
    logic            room;
    logic [Q_CW-1:0] level;

    updec_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (room),
        .o_push  (push)
    );

    updec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_level (level),
        .o_out   (o_out)
    );

    // queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= Q_CW'(Q_DEPTH))
        else $error("result queue overflow");

    // only pushes when there is room for two
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd0 |-> room)
        else $error("push without room");

    // an end mark on slot 0 only comes with a single result
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.count != 2'd0 && push.res0.last) |-> push.count == 2'd1)
        else $error("end mark on wrong slot");

    a_two_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count == 2'd2 |-> !push.res0.last)
        else $error("end mark before second result");

endmodule

/* test/tb_url_percent_decoder.sv */
// tb_url_percent_decoder: self-checking testbench for the URL percent-decoder.
// Depends on updec_pkg, updec_in_if, updec_out_if and url_percent_decoder.
// Directed escapes first, then random strings with broken escapes and noise.

module tb_url_percent_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import updec_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 20;

    // Tracks the escape phase and holds the decoded bytes still owed by the block.
    class decode_scoreboard;
        t_phase     phase;
        logic [3:0] nibble;
        t_res       owed[$];
        int         failures;

        function new();
            phase    = PH_IDLE;
            nibble   = 4'd0;
            failures = 0;
        endfunction

        static function bit hex_digit(input logic [7:0] c, output logic [3:0] v);
            logic [7:0] t;
            t = 8'd0;
            hex_digit = 1'b1;
            if (c >= 8'h30 && c <= 8'h39) begin
                t = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                t = c - 8'h37;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                t = c - 8'h57;
            end else begin
                hex_digit = 1'b0;
            end
            v = t[3:0];
        endfunction

        function void owe(input logic [7:0] d);
            t_res r;
            r.data = d;
            r.last = 1'b0;
            owed.push_back(r);
        endfunction

        function void ordinary(input logic [7:0] b);
            if (b == CH_PLUS) begin
                owe(CH_SPACE);
            end else if (b == CH_PCT) begin
                phase = PH_PCT;
            end else begin
                owe(b);
            end
        endfunction

        function void note_input(input logic [7:0] b, input logic is_last);
            logic [3:0] v;
            bit         is_hex;
            int         owed_start;
            t_res       r;
            owed_start = owed.size();
            is_hex = hex_digit(b, v);
            case (phase)
                PH_PCT: begin
                    if (is_hex) begin
                        nibble = v;
                        phase  = PH_HEX1;
                    end else begin
                        owe(CH_PCT);
                        phase = PH_IDLE;
                        ordinary(b);
                    end
                end
                PH_HEX1: begin
                    phase = PH_IDLE;
                    if (is_hex) begin
                        owe({nibble, v});
                    end else begin
                        owe({4'h0, nibble});
                        ordinary(b);
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    ordinary(b);
                end
            endcase
            if (is_last) begin
                // flush whatever escape is still open
                if (phase == PH_PCT) begin
                    owe(CH_PCT);
                end else if (phase == PH_HEX1) begin
                    owe({4'h0, nibble});
                end
                phase  = PH_IDLE;
                nibble = 4'd0;
                if (owed.size() > owed_start) begin
                    r = owed.pop_back();
                    r.last = 1'b1;
                    owed.push_back(r);
                end
            end
        endfunction

        function void report(input string what, input t_res want, input t_res got);
            failures++;
            if (failures <= 10) begin
                $display("%s: expected byte %h last %b, got byte %h last %b",
                         what, want.data, want.last, got.data, got.last);
            end
        endfunction

        function void check_result(input logic [7:0] d, input logic is_last);
            t_res want;
            t_res got;
            got.data = d;
            got.last = is_last;
            if (owed.size() == 0) begin
                want = '0;
                report("unexpected item", want, got);
            end else begin
                want = owed.pop_front();
                if (want.data !== got.data || want.last !== got.last) begin
                    report("mismatch", want, got);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   calm;
    int   hold_asked;
    int   sent;

    decode_scoreboard sb;

    updec_in_if  in_ch ();
    updec_out_if out_ch ();

    url_percent_decoder dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_input(in_ch.in_byte, in_ch.in_last);
        end
        if (rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.out_byte, out_ch.out_last);
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin : sink_side
        int hold_done;
        int hold_left;
        hold_done = 0;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_asked != hold_done) begin
                hold_done = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= 6);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (!calm && $urandom_range(99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= is_last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_hex();
        case ($urandom_range(2))
            0:       rand_hex = 8'(8'h30 + $urandom_range(9));
            1:       rand_hex = 8'(8'h41 + $urandom_range(5));
            default: rand_hex = 8'(8'h61 + $urandom_range(5));
        endcase
    endfunction

    // a byte that breaks an escape; percent and plus are favoured
    function automatic logic [7:0] rand_breaker();
        logic [7:0] c;
        logic [3:0] v;
        case ($urandom_range(3))
            0: c = CH_PCT;
            1: c = CH_PLUS;
            default: begin
                c = 8'($urandom_range(255));
                while (decode_scoreboard::hex_digit(c, v)) c = 8'($urandom_range(255));
            end
        endcase
        return c;
    endfunction

    // string of tokens, some with broken escapes, sometimes with an escape left open at the end
    task automatic send_string();
        logic [7:0] s[$];
        int         tokens;
        tokens = $urandom_range(1, 5);
        repeat (tokens) begin
            case ($urandom_range(5))
                0: s.push_back(8'($urandom_range(255)));
                1: s.push_back(CH_PLUS);
                2: begin
                    s.push_back(CH_PCT);
                    s.push_back(rand_hex());
                    s.push_back(rand_hex());
                end
                3: begin
                    s.push_back(CH_PCT);
                    s.push_back(rand_breaker());
                end
                4: begin
                    s.push_back(CH_PCT);
                    s.push_back(rand_hex());
                    s.push_back(rand_breaker());
                end
                default: s.push_back(8'h00);
            endcase
        end
        case ($urandom_range(4))
            0: s.push_back(CH_PCT);
            1: begin
                s.push_back(CH_PCT);
                s.push_back(rand_hex());
            end
            default: ;
        endcase
        foreach (s[k]) send_byte(s[k], k == s.size() - 1);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 6)) begin
            send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
        end
    endtask

    initial begin : stimulus
        bit held;
        bit drained;
        int base;
        held       = 1'b0;
        drained    = 1'b0;
        calm       = 1'b0;
        hold_asked = 0;
        sent       = 0;
        sb         = new();
        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.in_last <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'h00, 1'b1);        // zero byte alone
        send_byte(8'hFF, 1'b0);
        send_byte(CH_PLUS, 1'b1);
        send_byte(CH_PCT, 1'b0);       // %4a, lower-case digit
        send_byte(8'h34, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(CH_PCT, 1'b0);       // %Ff, mixed case
        send_byte(8'h46, 1'b0);
        send_byte(8'h66, 1'b0);
        send_byte(CH_PCT, 1'b0);       // percent then non-hex
        send_byte(8'h47, 1'b0);
        send_byte(CH_PCT, 1'b0);       // one digit then non-hex
        send_byte(8'h33, 1'b0);
        send_byte(8'h7A, 1'b0);
        send_byte(CH_PCT, 1'b0);       // double percent, then plus breaks it
        send_byte(CH_PCT, 1'b0);
        send_byte(CH_PLUS, 1'b1);
        send_byte(CH_PCT, 1'b1);       // lone percent on the last byte
        send_byte(CH_PCT, 1'b0);       // one digit on the last byte
        send_byte(8'h37, 1'b1);
        send_byte(CH_PCT, 1'b0);       // digit broken by a new escape
        send_byte(8'h35, 1'b0);
        send_byte(CH_PCT, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        drain();

        base = sent;
        while (sent - base < RANDOM_ITEMS) begin
            if (!held && sent - base >= 400) begin
                held = 1'b1;
                hold_asked++;
            end
            if (!drained && sent - base >= 1000) begin
                drained = 1'b1;
                drain();
            end
            calm = (sent - base >= 1200) && (sent - base < 1500);
            if ($urandom_range(99) < 85) begin
                send_string();
            end else begin
                send_noise();
            end
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.owed.size() != 0) begin
            $display("%0d decoded bytes never arrived", sb.owed.size());
            sb.failures++;
        end
        if (sb.failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* url_percent_decoder.f */
sv/updec_pkg.sv
sv/updec_in_if.sv
sv/updec_out_if.sv
sv/updec_dec.sv
sv/updec_queue.sv
sv/url_percent_decoder.sv
test/tb_url_percent_decoder.sv
